// ===== hw/rtl/sparse_table_range_min_assert.svh =====
// assertion macros used by the checker file of the range-min block
// depends on nothing; included by bare file name
`ifndef SPARSE_TABLE_RANGE_MIN_ASSERT_SVH
`define SPARSE_TABLE_RANGE_MIN_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define STRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range-min check failed in the same cycle");

// consequent must hold in the cycle after the antecedent
`define STRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("range-min check failed one cycle later");

`endif

// ===== hw/rtl/strm_pkg.sv =====
// shared types and constants of the sparse table range-min block
// no dependencies; used by the controller, datapath and top level
package strm_pkg;

    // default sizing
    localparam int MAX_ELEMENTS_DEF = 256;
    localparam int VALUE_WIDTH_DEF  = 32;

    // port field widths
    localparam int POS_W       = 8;
    localparam int IN_VALUE_W  = 32;
    localparam int LEFT_W      = 8;
    localparam int RIGHT_W     = 9;
    localparam int OUT_VALUE_W = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0]  REG_USED_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_TAKE_MAX    = 2'd1;
    localparam logic [CFG_DATA_W-1:0] USED_LENGTH_RST = 9'd256;

    // request kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic clear;       // zero one element during the reset sweep
        logic accept;      // take an input request
        logic build_init;  // start a table rebuild at level one
        logic b_tread;     // rebuild: read two winners of the level below
        logic b_eread;     // rebuild: read the two candidate elements
        logic b_write;     // rebuild: store the winner, step to next entry
        logic q_tread;     // query: read the two window winners
        logic q_eread;     // query: read the two winning elements
        logic load_out;    // load the result register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic q_err;       // request on the input ports is a bad range
        logic clear_last;  // reset sweep is at its last element
        logic build_none;  // used length too short for any table level
        logic entry_last;  // last entry of the current level
        logic level_last;  // current level is the top one
        logic out_free;    // result register can take a new result
    } t_dp_status;

endpackage

// ===== hw/rtl/strm_ram.sv =====
// generic memory: one write port, two read ports with registered data
// no dependencies beyond the package defaults
module strm_ram #(
    parameter int WIDTH = strm_pkg::VALUE_WIDTH_DEF,
    parameter int DEPTH = strm_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, data held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hw/rtl/strm_ctrl.sv =====
// controller state machine: reset sweep, request intake, rebuild and query
// sequencing; depends on strm_pkg command and status types
module strm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_mode,
    input  logic                i_cfg_we,
    input  strm_pkg::t_dp_status i_status,
    output logic                o_in_stall,
    output strm_pkg::t_dp_cmd   o_cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_BTRD  = 3'd2;
    localparam logic [2:0] ST_BERD  = 3'd3;
    localparam logic [2:0] ST_BWR   = 3'd4;
    localparam logic [2:0] ST_QTRD  = 3'd5;
    localparam logic [2:0] ST_QERD  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_table_ok;
    logic       n_table_ok;

    // next state, table freshness and commands
    always_comb begin
        n_state    = r_state;
        n_table_ok = r_table_ok;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        if (i_cfg_we) begin
            n_table_ok = 1'b0;
        end
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_mode == strm_pkg::MODE_WRITE) begin
                        n_table_ok = 1'b0;
                    end else if (i_status.q_err) begin
                        n_state = ST_DONE;
                    end else if (!r_table_ok) begin
                        o_cmd.build_init = 1'b1;
                        if (i_status.build_none) begin
                            n_table_ok = 1'b1;
                            n_state    = ST_QTRD;
                        end else begin
                            n_state = ST_BTRD;
                        end
                    end else begin
                        n_state = ST_QTRD;
                    end
                end
            end
            ST_BTRD: begin
                o_cmd.b_tread = 1'b1;
                n_state       = ST_BERD;
            end
            ST_BERD: begin
                o_cmd.b_eread = 1'b1;
                n_state       = ST_BWR;
            end
            ST_BWR: begin
                o_cmd.b_write = 1'b1;
                if (i_status.entry_last && i_status.level_last) begin
                    n_table_ok = 1'b1;
                    n_state    = ST_QTRD;
                end else begin
                    n_state = ST_BTRD;
                end
            end
            ST_QTRD: begin
                o_cmd.q_tread = 1'b1;
                n_state       = ST_QERD;
            end
            ST_QERD: begin
                o_cmd.q_eread = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_table_ok <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_table_ok <= n_table_ok;
        end
    end

endmodule

// ===== hw/rtl/strm_dp.sv =====
// datapath: config registers, element and winner memories, range checks,
// rebuild counters and result register; depends on strm_pkg and strm_ram
module strm_dp #(
    parameter int MAX_ELEMENTS = strm_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = strm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  strm_pkg::t_dp_cmd                  i_cmd,
    output strm_pkg::t_dp_status               o_status,
    input  logic                               i_cfg_we,
    input  logic [strm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [strm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_mode,
    input  logic [strm_pkg::POS_W-1:0]         i_write_position,
    input  logic [strm_pkg::IN_VALUE_W-1:0]    i_write_value,
    input  logic [strm_pkg::LEFT_W-1:0]        i_range_left,
    input  logic [strm_pkg::RIGHT_W-1:0]       i_range_right,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [strm_pkg::OUT_VALUE_W-1:0]   o_extreme_value,
    output logic                               o_range_error
);

    localparam int IDX_W      = $clog2(MAX_ELEMENTS);
    localparam int CNT_W      = $clog2(MAX_ELEMENTS + 1);
    localparam int TBL_LEVELS = CNT_W - 1;
    localparam int LVL_W      = $clog2(TBL_LEVELS + 1);
    localparam int TBL_DEPTH  = TBL_LEVELS * MAX_ELEMENTS;
    localparam int TAW        = $clog2(TBL_DEPTH);
    localparam int LEN_W      = (CNT_W > strm_pkg::CFG_DATA_W) ? CNT_W : strm_pkg::CFG_DATA_W;
    localparam int E_W        = LEN_W + 1;
    localparam int K_W        = $clog2(strm_pkg::RIGHT_W);

    // configuration registers
    logic [strm_pkg::CFG_DATA_W-1:0] r_used_length;
    logic                            r_take_max;

    // latched query
    logic [IDX_W-1:0]             r_left;
    logic [strm_pkg::RIGHT_W-1:0] r_right;
    logic [LVL_W-1:0]             r_k;
    logic                         r_err;

    // rebuild counters
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] n_j;
    logic [LVL_W-1:0] r_lvl;
    logic [LVL_W-1:0] n_lvl;

    // candidate indices and result register
    logic [IDX_W-1:0]                 r_a;
    logic [IDX_W-1:0]                 r_b;
    logic                             r_out_valid;
    logic                             n_out_valid;
    logic [strm_pkg::OUT_VALUE_W-1:0] r_out_value;
    logic                             r_out_err;

    logic [CNT_W-1:0]             active;
    logic [LEN_W-1:0]             len_ext;
    logic [strm_pkg::RIGHT_W-1:0] span;
    logic [K_W-1:0]               k_span;
    logic                         pos_ok;
    logic                         is_build;
    logic                         direct;
    logic [LVL_W-1:0]             row;
    logic [IDX_W-1:0]             t_idx_a;
    logic [IDX_W-1:0]             t_idx_b;
    logic                         t_re;
    logic                         t_we;
    logic [TAW-1:0]               t_raddr_a;
    logic [TAW-1:0]               t_raddr_b;
    logic [TAW-1:0]               t_waddr;
    logic [IDX_W-1:0]             t_rdata_a;
    logic [IDX_W-1:0]             t_rdata_b;
    logic                         e_we;
    logic                         e_re;
    logic [IDX_W-1:0]             e_waddr;
    logic [VALUE_WIDTH-1:0]       e_wdata;
    logic [IDX_W-1:0]             e_raddr_a;
    logic [IDX_W-1:0]             e_raddr_b;
    logic [VALUE_WIDTH-1:0]       e_rdata_a;
    logic [VALUE_WIDTH-1:0]       e_rdata_b;
    logic                         a_wins;

    // used length clipped to the store size
    assign len_ext = LEN_W'(r_used_length);
    assign active  = (len_ext > LEN_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                       : CNT_W'(r_used_length);

    // range check and window level from the input ports
    assign span = i_range_right - strm_pkg::RIGHT_W'(i_range_left);

    always_comb begin
        k_span = '0;
        for (int b = 0; b < strm_pkg::RIGHT_W; b++) begin
            if (span[b]) begin
                k_span = K_W'(b);
            end
        end
    end

    assign o_status.q_err = (LEN_W'(i_range_left) >= LEN_W'(i_range_right))
                         || (LEN_W'(i_range_right) > LEN_W'(active));

    // status toward the controller
    assign o_status.clear_last = (r_j == IDX_W'(MAX_ELEMENTS - 1));
    assign o_status.build_none = (active < CNT_W'(2));
    assign o_status.entry_last = (E_W'(r_j) + E_W'(1) + (E_W'(1) << r_lvl)) > E_W'(active);
    assign o_status.level_last = (E_W'(2) << r_lvl) > E_W'(active);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_length <= strm_pkg::USED_LENGTH_RST;
            r_take_max    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                strm_pkg::REG_USED_LENGTH: r_used_length <= i_cfg_data;
                strm_pkg::REG_TAKE_MAX:    r_take_max    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // query latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_left  <= IDX_W'(i_range_left);
            r_right <= i_range_right;
            r_k     <= LVL_W'(k_span);
            r_err   <= o_status.q_err;
        end
    end

    // rebuild and sweep counters
    always_comb begin
        n_j   = r_j;
        n_lvl = r_lvl;
        if (i_cmd.clear) begin
            n_j = r_j + IDX_W'(1);
        end else if (i_cmd.build_init) begin
            n_j   = '0;
            n_lvl = LVL_W'(1);
        end else if (i_cmd.b_write) begin
            if (o_status.entry_last) begin
                n_j = '0;
                if (!o_status.level_last) begin
                    n_lvl = r_lvl + LVL_W'(1);
                end
            end else begin
                n_j = r_j + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j   <= '0;
            r_lvl <= LVL_W'(1);
        end else begin
            r_j   <= n_j;
            r_lvl <= n_lvl;
        end
    end

    // winner table read addresses for rebuild or query
    assign is_build = i_cmd.b_tread || i_cmd.b_eread;
    assign row      = is_build ? (r_lvl - LVL_W'(2)) : (r_k - LVL_W'(1));
    assign t_idx_a  = is_build ? r_j : r_left;
    assign t_idx_b  = is_build ? (r_j + (IDX_W'(1) << (r_lvl - LVL_W'(1))))
                               : IDX_W'(LEN_W'(r_right) - (LEN_W'(1) << r_k));
    assign t_raddr_a = TAW'(row) * TAW'(MAX_ELEMENTS) + TAW'(t_idx_a);
    assign t_raddr_b = TAW'(row) * TAW'(MAX_ELEMENTS) + TAW'(t_idx_b);
    assign t_re = (i_cmd.b_tread && (r_lvl != LVL_W'(1)))
               || (i_cmd.q_tread && (r_k != '0));

    // element read addresses: level one and single-element ranges skip the table
    assign direct    = i_cmd.b_eread ? (r_lvl == LVL_W'(1)) : (r_k == '0);
    assign e_raddr_a = direct ? (i_cmd.b_eread ? r_j : r_left) : t_rdata_a;
    assign e_raddr_b = direct ? (i_cmd.b_eread ? (r_j + IDX_W'(1)) : r_left) : t_rdata_b;
    assign e_re      = i_cmd.b_eread || i_cmd.q_eread;

    always_ff @(posedge i_clk) begin
        if (e_re) begin
            r_a <= e_raddr_a;
            r_b <= e_raddr_b;
        end
    end

    // element writes from the reset sweep or a write request
    assign pos_ok  = LEN_W'(i_write_position) < LEN_W'(MAX_ELEMENTS);
    assign e_we    = i_cmd.clear
                  || (i_cmd.accept && (i_mode == strm_pkg::MODE_WRITE) && pos_ok);
    assign e_waddr = i_cmd.clear ? r_j : IDX_W'(i_write_position);
    assign e_wdata = i_cmd.clear ? '0 : VALUE_WIDTH'(i_write_value);

    // winner pick, right side on ties
    assign a_wins = r_take_max ? (e_rdata_a > e_rdata_b) : (e_rdata_a < e_rdata_b);

    // rebuilt winner goes to the current level
    assign t_we    = i_cmd.b_write;
    assign t_waddr = TAW'(r_lvl - LVL_W'(1)) * TAW'(MAX_ELEMENTS) + TAW'(r_j);

    strm_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_elem_ram (
        .i_clk     (i_clk),
        .i_we      (e_we),
        .i_waddr   (e_waddr),
        .i_wdata   (e_wdata),
        .i_re      (e_re),
        .i_raddr_a (e_raddr_a),
        .i_raddr_b (e_raddr_b),
        .o_rdata_a (e_rdata_a),
        .o_rdata_b (e_rdata_b)
    );

    strm_ram #(
        .WIDTH (IDX_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .i_clk     (i_clk),
        .i_we      (t_we),
        .i_waddr   (t_waddr),
        .i_wdata   (a_wins ? r_a : r_b),
        .i_re      (t_re),
        .i_raddr_a (t_raddr_a),
        .i_raddr_b (t_raddr_b),
        .o_rdata_a (t_rdata_a),
        .o_rdata_b (t_rdata_b)
    );

    // result register
    assign n_out_valid = i_cmd.load_out ? 1'b1 : (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value <= r_err ? '0
                         : strm_pkg::OUT_VALUE_W'(a_wins ? e_rdata_a : e_rdata_b);
            r_out_err   <= r_err;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_extreme_value = r_out_value;
    assign o_range_error   = r_out_err;

endmodule

// ===== hw/rtl/sparse_table_range_min.sv =====
// sparse table range-min top level; uses strm_pkg, strm_ctrl, strm_dp.
// write request: accepted without leaving idle. bad-range query: result loaded without any memory read.
// query on a fresh table: table read, element read, then compare into the result register.
// after a write or config change the next good query first rebuilds the table,
// one entry at a time (table read, element read, winner write) over all levels.
// reset: synchronous, then a sweep over all MAX_ELEMENTS entries zeroes the element memory.
module sparse_table_range_min #(
    parameter int MAX_ELEMENTS = strm_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = strm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [strm_pkg::POS_W-1:0]       i_write_position,
    input  logic [strm_pkg::IN_VALUE_W-1:0]  i_write_value,
    input  logic [strm_pkg::LEFT_W-1:0]      i_range_left,
    input  logic [strm_pkg::RIGHT_W-1:0]     i_range_right,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [strm_pkg::OUT_VALUE_W-1:0] o_extreme_value,
    output logic                             o_range_error,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [strm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [strm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    strm_pkg::t_dp_cmd    cmd;
    strm_pkg::t_dp_status status;
    logic                 cfg_we;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    strm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_cfg_we   (cfg_we),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    strm_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_mode),
        .i_write_position (i_write_position),
        .i_write_value    (i_write_value),
        .i_range_left     (i_range_left),
        .i_range_right    (i_range_right),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_extreme_value  (o_extreme_value),
        .o_range_error    (o_range_error)
    );

endmodule

// ===== hw/rtl/strm_check.sv =====
// port-level checks for the range-min top level, attached with bind
// depends on strm_pkg and sparse_table_range_min_assert.svh
`include "sparse_table_range_min_assert.svh"

module strm_check (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             i_mode,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [strm_pkg::OUT_VALUE_W-1:0] o_extreme_value,
    input logic                             o_range_error
);

    // a held result keeps its payload
    `STRM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_extreme_value) && $stable(o_range_error))

    // an error result carries a zero value
    `STRM_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_out_valid && o_range_error, o_extreme_value == '0)

    // a query request keeps the input closed on the next cycle
    `STRM_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_mode == strm_pkg::MODE_QUERY), o_in_stall)

    // a write request leaves the input open on the next cycle
    `STRM_ASSERT_NEXT(a_write_fast, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_mode == strm_pkg::MODE_WRITE), !o_in_stall)

endmodule

bind sparse_table_range_min strm_check u_strm_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_mode          (i_mode),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_extreme_value (o_extreme_value),
    .o_range_error   (o_range_error)
);
